// ===== hdl/asfm_pkg.sv =====
// Package for the adaptive symbol frequency model.
// Holds sizes, opcode and status codes, and the controller/datapath structs.
// No dependencies.
package asfm_pkg;

    localparam int MAX_SYMBOLS   = 2048;
    localparam int PROB_BITS     = 15;
    localparam int TABLE_ENTRIES = 514;

    localparam int SYM_AW = $clog2(MAX_SYMBOLS);
    localparam int TBL_AW = $clog2(TABLE_ENTRIES);
    localparam int CUM_W  = PROB_BITS + 1;

    localparam logic [16:0] TOTAL_SAT = 17'h1FFFF;
    localparam logic [17:0] PROB_ONE  = 18'(1) << PROB_BITS;
    localparam logic [31:0] DIVIDEND  = 32'h8000_0000;

    typedef enum logic [2:0] {
        OP_INIT_ONES   = 3'd0,
        OP_WRITE_COUNT = 3'd1,
        OP_INIT_LOADED = 3'd2,
        OP_INCREMENT   = 3'd3,
        OP_READ_DIST   = 3'd4,
        OP_READ_TABLE  = 3'd5,
        OP_READ_COUNT  = 3'd6,
        OP_UNUSED      = 3'd7
    } opcode_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_READY = 2'd1;
    localparam logic [1:0] ST_BAD_INDEX = 2'd2;

    typedef enum logic [1:0] {
        RV_ZERO,
        RV_COUNT,
        RV_CUM,
        RV_TABLE
    } rv_sel_t;

    typedef struct packed {
        logic       capture;
        logic       k_clear;
        logic       k_inc;
        logic       cnt_rd_k;
        logic       ones_write;
        logic       write_count;
        logic       inc_write;
        logic       geom;
        logic       rb_start;
        logic       halve_write;
        logic       div_start;
        logic       cum_init;
        logic       cum_write;
        logic       tbl_fill;
        logic       tail0;
        logic       tail_fill;
        logic       period_update;
        logic       result_set;
        rv_sel_t    rv_sel;
        logic [1:0] st_code;
        logic       load_out;
    } dp_cmd_t;

    typedef struct packed {
        opcode_t op;
        logic    idx_ge_n;
        logic    model_ready;
        logic    has_table;
        logic    idx_ge_tbl;
        logic    cd_last;
        logic    rb_over;
        logic    last_k;
        logic    div_done;
        logic    fill_need;
        logic    fill_last;
        logic    build;
        logic    tail_need;
        logic    tail_last;
        logic    out_full;
    } dp_status_t;

endpackage

// ===== hdl/asfm_in_if.sv =====
// Input request channel of the adaptive symbol frequency model.
// Carries valid, ready and the request payload; no dependencies.
interface asfm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  opcode;
    logic [10:0] entry_index;
    logic [15:0] count_value;

    modport source(output valid, output opcode, output entry_index, output count_value,
                   input ready);
    modport sink(input valid, input opcode, input entry_index, input count_value,
                 output ready);
endinterface

// ===== hdl/asfm_out_if.sv =====
// Result channel of the adaptive symbol frequency model.
// Carries valid, ready and the result payload; no dependencies.
interface asfm_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic        table_in_use;

    modport source(output valid, output read_value, output status,
                   output table_in_use, input ready);
    modport sink(input valid, input read_value, input status,
                 input table_in_use, output ready);
endinterface

// ===== hdl/asfm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module asfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/asfm_datapath.sv =====
// Datapath of the adaptive symbol frequency model: the three memories,
// model registers, the iterative divider and the result register.
// Depends on asfm_pkg and asfm_ram.
module asfm_datapath import asfm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [11:0] symbol_count_in_use,
    input  logic        encoder_mode,
    input  logic [2:0]  req_opcode,
    input  logic [10:0] req_entry_index,
    input  logic [15:0] req_count_value,
    input  dp_cmd_t     cmd,
    output dp_status_t  sts,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [31:0] res_read_value,
    output logic [1:0]  res_status,
    output logic        res_table_in_use
);

    logic [2:0]        op_reg;
    logic [10:0]       idx_reg;
    logic [15:0]       val_reg;
    logic [11:0]       k_reg;
    logic [TBL_AW-1:0] s_reg;
    logic [TBL_AW-1:0] w_reg;
    logic [31:0]       sum_reg;
    logic [31:0]       prod_reg;
    logic [31:0]       scale_reg;
    logic [16:0]       total_reg;
    logic [16:0]       acc_reg;
    logic [14:0]       period_reg;
    logic [14:0]       countdown_reg;
    logic [3:0]        lookup_bits_reg;
    logic              model_ready_reg;
    logic              init_pend_reg;
    logic [16:0]       rem_reg;
    logic [31:0]       quo_reg;
    logic [5:0]        div_cnt_reg;
    logic [31:0]       rv_reg;
    logic [1:0]        st_reg;
    logic              out_valid_reg;
    logic [31:0]       out_rv_reg;
    logic [1:0]        out_st_reg;
    logic              out_tbl_reg;

    logic [11:0]       n_eff;
    logic [TBL_AW-1:0] tsize;
    logic [TBL_AW-1:0] s_inc;
    logic [31:0]       cnt_rdata;
    logic [CUM_W-1:0]  cum_rdata;
    logic [10:0]       tbl_rdata;
    logic [17:0]       t_sum;
    logic [31:0]       halved;
    logic [32:0]       acc_wide;
    logic [16:0]       acc_next;
    logic [CUM_W-1:0]  d_val;
    logic [CUM_W-1:0]  w_wide;
    logic [TBL_AW-1:0] w_clamp;
    logic [16:0]       divisor;
    logic [17:0]       rem_shift;
    logic              rem_ge;
    logic [16:0]       per_x5;
    logic [14:0]       per_new;
    logic [14:0]       per_cap;
    logic [11:0]       n_plus6;
    logic              build;

    logic                cnt_we;
    logic [SYM_AW-1:0]   cnt_waddr;
    logic [31:0]         cnt_wdata;
    logic [SYM_AW-1:0]   cnt_raddr;
    logic                tbl_we;
    logic [TBL_AW-1:0]   tbl_waddr;
    logic [10:0]         tbl_wdata;

    function automatic logic [3:0] lookup_width(input logic [11:0] n);
        logic [3:0] tb;
        tb = 4'd3;
        for (int i = 3; i < 12; i++)
        begin
            if ({20'd0, n} > (32'd1 << (i + 2)))
            begin
                tb = 4'(i + 1);
            end
        end
        return tb;
    endfunction

    function automatic logic [TBL_AW-1:0] s_inc_lim(input logic [TBL_AW-1:0] ts);
        return ts + TBL_AW'(1);
    endfunction

    always_comb
    begin
        if (symbol_count_in_use < 12'd2)
            n_eff = 12'd2;
        else if (symbol_count_in_use > 12'(MAX_SYMBOLS))
            n_eff = 12'(MAX_SYMBOLS);
        else
            n_eff = symbol_count_in_use;
    end

    assign n_plus6 = n_eff + 12'd6;
    assign tsize   = TBL_AW'(1) << lookup_bits_reg;
    assign s_inc   = s_reg + TBL_AW'(1);
    assign build   = !encoder_mode && (lookup_bits_reg != 4'd0);

    assign t_sum    = {1'b0, total_reg} + {3'b0, period_reg};
    assign halved   = {1'b0, cnt_rdata[31:1]} + {31'd0, cnt_rdata[0]};
    assign acc_wide = {16'd0, acc_reg} + {1'b0, halved};
    assign acc_next = (acc_wide > {16'd0, TOTAL_SAT}) ? TOTAL_SAT : acc_wide[16:0];

    // Cumulative entry is the top bits of the wrapped 32-bit product.
    assign d_val   = prod_reg[31:31-PROB_BITS];
    assign w_wide  = d_val >> (4'(PROB_BITS) - lookup_bits_reg);
    assign w_clamp = (w_wide > CUM_W'(s_inc_lim(tsize))) ? s_inc_lim(tsize)
                                                         : w_wide[TBL_AW-1:0];

    assign divisor   = (total_reg == 17'd0) ? 17'd1 : total_reg;
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_ge    = rem_shift >= {1'b0, divisor};

    assign per_x5  = {period_reg, 2'b00} + {2'b00, period_reg};
    assign per_cap = {n_plus6, 3'b000};
    assign per_new = (per_x5[16:2] > per_cap) ? per_cap : per_x5[16:2];

    // Memory write and read port selection.
    always_comb
    begin
        cnt_we    = 1'b0;
        cnt_waddr = k_reg[SYM_AW-1:0];
        cnt_wdata = 32'd1;
        if (cmd.ones_write)
        begin
            cnt_we = 1'b1;
        end
        else if (cmd.write_count)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg[SYM_AW-1:0];
            cnt_wdata = {16'd0, val_reg};
        end
        else if (cmd.inc_write)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = idx_reg[SYM_AW-1:0];
            cnt_wdata = cnt_rdata + 32'd1;
        end
        else if (cmd.halve_write)
        begin
            cnt_we    = 1'b1;
            cnt_wdata = halved;
        end
    end

    assign cnt_raddr = cmd.cnt_rd_k ? k_reg[SYM_AW-1:0] : idx_reg[SYM_AW-1:0];

    always_comb
    begin
        tbl_we    = 1'b0;
        tbl_waddr = s_inc;
        tbl_wdata = k_reg[10:0] - 11'd1;
        if (cmd.tbl_fill)
        begin
            tbl_we = ({22'd0, s_inc} < 32'(TABLE_ENTRIES));
        end
        else if (cmd.tail0)
        begin
            tbl_we    = 1'b1;
            tbl_waddr = '0;
            tbl_wdata = 11'd0;
        end
        else if (cmd.tail_fill)
        begin
            tbl_we    = ({22'd0, s_inc} < 32'(TABLE_ENTRIES));
            tbl_wdata = n_eff[10:0] - 11'd1;
        end
    end

    asfm_ram #(.WIDTH(32), .DEPTH(MAX_SYMBOLS)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    asfm_ram #(.WIDTH(CUM_W), .DEPTH(MAX_SYMBOLS)) u_cumulative (
        .clk   (clk),
        .we    (cmd.cum_write),
        .waddr (k_reg[SYM_AW-1:0]),
        .wdata (d_val),
        .raddr (idx_reg[SYM_AW-1:0]),
        .rdata (cum_rdata)
    );

    asfm_ram #(.WIDTH(11), .DEPTH(TABLE_ENTRIES)) u_decode_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (idx_reg[TBL_AW-1:0]),
        .rdata (tbl_rdata)
    );

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        prod_reg <= scale_reg * sum_reg;
        if (cmd.capture)
        begin
            op_reg  <= req_opcode;
            idx_reg <= req_entry_index;
            val_reg <= req_count_value;
        end
        if (cmd.k_clear || cmd.cum_init)
            k_reg <= 12'd0;
        else if (cmd.k_inc)
            k_reg <= k_reg + 12'd1;
        if (cmd.rb_start)
            acc_reg <= 17'd0;
        else if (cmd.halve_write)
            acc_reg <= acc_next;
        if (cmd.cum_init)
        begin
            scale_reg <= quo_reg;
            sum_reg   <= 32'd0;
            s_reg     <= '0;
        end
        else if (cmd.cum_write)
        begin
            sum_reg <= sum_reg + cnt_rdata;
            w_reg   <= w_clamp;
        end
        else if (cmd.tbl_fill || cmd.tail_fill)
        begin
            s_reg <= s_inc;
        end
        if (cmd.div_start)
        begin
            rem_reg <= 17'd0;
            quo_reg <= DIVIDEND;
        end
        else if (div_cnt_reg != 6'd32)
        begin
            rem_reg <= rem_ge ? 17'(rem_shift - {1'b0, divisor}) : rem_shift[16:0];
            quo_reg <= {quo_reg[30:0], rem_ge};
        end
        if (cmd.capture)
        begin
            rv_reg <= 32'd0;
            st_reg <= ST_OK;
        end
        else if (cmd.result_set)
        begin
            st_reg <= cmd.st_code;
            case (cmd.rv_sel)
                RV_COUNT: rv_reg <= cnt_rdata;
                RV_CUM:   rv_reg <= {{(32-CUM_W){1'b0}}, cum_rdata};
                RV_TABLE: rv_reg <= {21'd0, tbl_rdata};
                default:  rv_reg <= 32'd0;
            endcase
        end
        if (cmd.load_out)
        begin
            out_rv_reg  <= rv_reg;
            out_st_reg  <= st_reg;
            out_tbl_reg <= (lookup_bits_reg != 4'd0);
        end
    end

    // Model control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= 17'd0;
            period_reg      <= 15'd0;
            countdown_reg   <= 15'd0;
            lookup_bits_reg <= 4'd0;
            model_ready_reg <= 1'b0;
            init_pend_reg   <= 1'b0;
            div_cnt_reg     <= 6'd32;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.geom)
            begin
                lookup_bits_reg <= (!encoder_mode && n_eff > 12'd16) ? lookup_width(n_eff)
                                                                      : 4'd0;
                total_reg     <= 17'd0;
                period_reg    <= {3'd0, n_eff};
                init_pend_reg <= 1'b1;
            end
            else if (cmd.rb_start)
            begin
                if (t_sum <= PROB_ONE)
                    total_reg <= t_sum[16:0];
            end
            else if (cmd.halve_write && sts.last_k)
            begin
                total_reg <= acc_next;
            end
            else if (cmd.period_update)
            begin
                if (init_pend_reg)
                begin
                    period_reg      <= {4'd0, n_plus6[11:1]};
                    countdown_reg   <= {4'd0, n_plus6[11:1]};
                    model_ready_reg <= 1'b1;
                    init_pend_reg   <= 1'b0;
                end
                else
                begin
                    period_reg    <= per_new;
                    countdown_reg <= per_new;
                end
            end
            else if (cmd.inc_write && countdown_reg != 15'd0)
            begin
                countdown_reg <= countdown_reg - 15'd1;
            end
            if (cmd.div_start)
                div_cnt_reg <= 6'd0;
            else if (div_cnt_reg != 6'd32)
                div_cnt_reg <= div_cnt_reg + 6'd1;
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.op          = opcode_t'(op_reg);
        sts.idx_ge_n    = {1'b0, idx_reg} >= n_eff;
        sts.model_ready = model_ready_reg;
        sts.has_table   = lookup_bits_reg != 4'd0;
        sts.idx_ge_tbl  = ({1'b0, idx_reg} >= ({2'b0, tsize} + 12'd2))
                          || ({21'd0, idx_reg} >= 32'(TABLE_ENTRIES));
        sts.cd_last     = countdown_reg <= 15'd1;
        sts.rb_over     = t_sum > PROB_ONE;
        sts.last_k      = k_reg == (n_eff - 12'd1);
        sts.div_done    = div_cnt_reg == 6'd32;
        sts.fill_need   = build && (s_reg < w_clamp);
        sts.fill_last   = s_inc == w_reg;
        sts.build       = build;
        sts.tail_need   = s_reg <= tsize;
        sts.tail_last   = s_inc > tsize;
        sts.out_full    = out_valid_reg && !res_ready;
    end

    assign res_valid        = out_valid_reg;
    assign res_read_value   = out_rv_reg;
    assign res_status       = out_st_reg;
    assign res_table_in_use = out_tbl_reg;

endmodule

// ===== hdl/asfm_controller.sv =====
// Controller of the adaptive symbol frequency model: sequences requests,
// init passes and rebuilds by issuing commands to the datapath.
// Depends on asfm_pkg.
module asfm_controller import asfm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_ONES,
        S_GEOM,
        S_INC,
        S_RD,
        S_RB,
        S_HALVE_RD,
        S_HALVE_WR,
        S_DIV_GO,
        S_DIV,
        S_CUM_RD,
        S_CUM_WR,
        S_FILL,
        S_TAIL,
        S_TAIL_FILL,
        S_PERIOD,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.rv_sel  = RV_ZERO;
        cmd.st_code = ST_OK;
        req_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                case (sts.op)
                    OP_INIT_ONES:
                    begin
                        cmd.k_clear = 1'b1;
                        state_next  = S_ONES;
                    end
                    OP_INIT_LOADED:
                    begin
                        state_next = S_GEOM;
                    end
                    OP_WRITE_COUNT:
                    begin
                        if (sts.idx_ge_n)
                        begin
                            cmd.result_set = 1'b1;
                            cmd.st_code    = ST_BAD_INDEX;
                        end
                        else
                        begin
                            cmd.write_count = 1'b1;
                        end
                    end
                    OP_INCREMENT, OP_READ_DIST, OP_READ_COUNT:
                    begin
                        if (!sts.model_ready)
                        begin
                            cmd.result_set = 1'b1;
                            cmd.st_code    = ST_NOT_READY;
                        end
                        else if (sts.idx_ge_n)
                        begin
                            cmd.result_set = 1'b1;
                            cmd.st_code    = ST_BAD_INDEX;
                        end
                        else
                        begin
                            state_next = (sts.op == OP_INCREMENT) ? S_INC : S_RD;
                        end
                    end
                    OP_READ_TABLE:
                    begin
                        if (!sts.model_ready || !sts.has_table)
                        begin
                            cmd.result_set = 1'b1;
                            cmd.st_code    = ST_NOT_READY;
                        end
                        else if (sts.idx_ge_tbl)
                        begin
                            cmd.result_set = 1'b1;
                            cmd.st_code    = ST_BAD_INDEX;
                        end
                        else
                        begin
                            state_next = S_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_ONES:
            begin
                cmd.ones_write = 1'b1;
                cmd.k_inc      = 1'b1;
                if (sts.last_k)
                    state_next = S_GEOM;
            end
            S_GEOM:
            begin
                cmd.geom   = 1'b1;
                state_next = S_RB;
            end
            S_INC:
            begin
                cmd.inc_write = 1'b1;
                state_next    = sts.cd_last ? S_RB : S_FINISH;
            end
            S_RD:
            begin
                cmd.result_set = 1'b1;
                case (sts.op)
                    OP_READ_DIST:  cmd.rv_sel = RV_CUM;
                    OP_READ_TABLE: cmd.rv_sel = RV_TABLE;
                    default:       cmd.rv_sel = RV_COUNT;
                endcase
                state_next = S_FINISH;
            end
            S_RB:
            begin
                cmd.rb_start = 1'b1;
                cmd.k_clear  = 1'b1;
                state_next   = sts.rb_over ? S_HALVE_RD : S_DIV_GO;
            end
            S_HALVE_RD:
            begin
                cmd.cnt_rd_k = 1'b1;
                state_next   = S_HALVE_WR;
            end
            S_HALVE_WR:
            begin
                cmd.halve_write = 1'b1;
                cmd.k_inc       = 1'b1;
                cmd.cnt_rd_k    = 1'b1;
                state_next      = sts.last_k ? S_DIV_GO : S_HALVE_RD;
            end
            S_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.cum_init = 1'b1;
                    state_next   = S_CUM_RD;
                end
            end
            S_CUM_RD:
            begin
                cmd.cnt_rd_k = 1'b1;
                state_next   = S_CUM_WR;
            end
            S_CUM_WR:
            begin
                cmd.cum_write = 1'b1;
                cmd.cnt_rd_k  = 1'b1;
                if (sts.fill_need)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    cmd.k_inc = 1'b1;
                    if (sts.last_k)
                        state_next = sts.build ? S_TAIL : S_PERIOD;
                    else
                        state_next = S_CUM_RD;
                end
            end
            S_FILL:
            begin
                cmd.tbl_fill = 1'b1;
                cmd.cnt_rd_k = 1'b1;
                if (sts.fill_last)
                begin
                    cmd.k_inc = 1'b1;
                    if (sts.last_k)
                        state_next = S_TAIL;
                    else
                        state_next = S_CUM_RD;
                end
            end
            S_TAIL:
            begin
                cmd.tail0  = 1'b1;
                state_next = sts.tail_need ? S_TAIL_FILL : S_PERIOD;
            end
            S_TAIL_FILL:
            begin
                cmd.tail_fill = 1'b1;
                if (sts.tail_last)
                    state_next = S_PERIOD;
            end
            S_PERIOD:
            begin
                cmd.period_update = 1'b1;
                state_next        = S_FINISH;
            end
            S_FINISH:
            begin
                if (!sts.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/adaptive_symbol_frequency_model.sv =====
// Top level of the adaptive symbol frequency model: configuration registers,
// controller and datapath.
// Depends on asfm_pkg, asfm_in_if, asfm_out_if, asfm_controller, asfm_datapath.
//
//   Channel   Dir   Contents
//   req_ch    in    opcode, entry_index, count_value (valid/ready)
//   res_ch    out   read_value, status, table_in_use (valid/ready)
//   APB       in    reg 0 symbol_count_in_use @0x0, reg 1 encoder_mode @0x4
//
// One request at a time. A rebuild halves the counts (only when the total
// overflows), then runs the one-bit-per-cycle divider and the cumulative
// pass. Init with ones first writes a count of one to each of the n symbols.
// The result register lets a new request in while the previous result waits.
// Reset clears control only.
module adaptive_symbol_frequency_model import asfm_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    asfm_in_if.sink     req_ch,
    asfm_out_if.source  res_ch
);

    logic [11:0] sym_count_reg;
    logic        enc_mode_reg;
    dp_cmd_t     cmd;
    dp_status_t  sts;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_count_reg <= 12'd2;
            enc_mode_reg  <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2])
                enc_mode_reg <= pwdata[0];
            else
                sym_count_reg <= pwdata[11:0];
        end
    end

    assign prdata = paddr[2] ? {31'd0, enc_mode_reg} : {20'd0, sym_count_reg};

    asfm_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_ch.valid),
        .req_ready (req_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    asfm_datapath u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .symbol_count_in_use (sym_count_reg),
        .encoder_mode        (enc_mode_reg),
        .req_opcode          (req_ch.opcode),
        .req_entry_index     (req_ch.entry_index),
        .req_count_value     (req_ch.count_value),
        .cmd                 (cmd),
        .sts                 (sts),
        .res_valid           (res_ch.valid),
        .res_ready           (res_ch.ready),
        .res_read_value      (res_ch.read_value),
        .res_status          (res_ch.status),
        .res_table_in_use    (res_ch.table_in_use)
    );

endmodule
